[rtl/tty_serial_ring_buffer_engine_assert.svh]
// Assertion macros used by the engine top level.
`ifndef TTY_SERIAL_RING_BUFFER_ENGINE_ASSERT_SVH
`define TTY_SERIAL_RING_BUFFER_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tse_pkg.sv]
package tse_pkg;

   localparam int IN_DEPTH  = 64;
   localparam int OUT_DEPTH = 64;
   localparam int IN_AW     = $clog2(IN_DEPTH);
   localparam int IN_CW     = $clog2(IN_DEPTH + 1);
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

   localparam int CHAR_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int LEVEL_W = 7;

   localparam logic [CHAR_W-1:0] CH_ETX      = 7'h03;
   localparam logic [CHAR_W-1:0] CH_BS       = 7'h08;
   localparam logic [CHAR_W-1:0] CH_LF       = 7'h0A;
   localparam logic [CHAR_W-1:0] CH_VT       = 7'h0B;
   localparam logic [CHAR_W-1:0] CH_FF       = 7'h0C;
   localparam logic [CHAR_W-1:0] CH_CR       = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_ESC      = 7'h1B;
   localparam logic [CHAR_W-1:0] CH_A        = 7'h41;
   localparam logic [CHAR_W-1:0] CH_B        = 7'h42;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 7'h5B;
   localparam logic [CHAR_W-1:0] CH_DEL      = 7'h7F;

   localparam logic [1:0] ESC_IDLE  = 2'd0;
   localparam logic [1:0] ESC_SEEN  = 2'd1;
   localparam logic [1:0] ESC_CSI   = 2'd2;
   localparam logic [1:0] ESC_STUCK = 2'd3;

   typedef enum logic [1:0] {
      OP_RX    = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_TX    = 2'd3
   } tse_op_type;

   typedef struct packed {
      tse_op_type        op;
      logic [BYTE_W-1:0] data_in;
   } tse_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  read_char;
      logic               read_valid;
      logic               write_accepted;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_valid;
      logic               tx_irq_on;
      logic               break_flag;
      logic               overflow;
      logic [LEVEL_W-1:0] input_level;
      logic [LEVEL_W-1:0] output_space;
   } tse_rsp_type;

   typedef struct packed {
      logic start;
      logic finish;
   } tse_cmd_type;

endpackage

[rtl/tse_ctrl.sv]
module tse_ctrl
   import tse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tse_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_FINISH = 2'b10
   } tse_state_type;

   tse_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.start  = req_valid && req_ready;
   assign cmd.finish = (state_ff == ST_FINISH) && slot_free;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/tse_datapath.sv]
module tse_datapath
   import tse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tse_cmd_type cmd,
   input  tse_req_type req,
   output tse_rsp_type rsp
);

   logic [CHAR_W-1:0] in_mem  [IN_DEPTH];
   logic [BYTE_W-1:0] out_mem [OUT_DEPTH];

   logic [IN_AW-1:0]  in_wptr_ff, in_wptr_in, in_rptr_ff, in_rptr_in;
   logic [IN_CW-1:0]  in_count_ff, in_count_in;
   logic [OUT_AW-1:0] out_wptr_ff, out_wptr_in, out_rptr_ff, out_rptr_in;
   logic [OUT_CW-1:0] out_space_ff, out_space_in;
   logic              tx_en_ff, tx_en_in;
   logic [1:0]        stage_ff, stage_in;

   logic lf_pend_ff, lf_pend_in;
   logic ovf_ff, ovf_in;
   logic brk_ff, brk_in;
   logic rdv_ff, rdv_in;
   logic wra_ff, wra_in;
   logic txv_ff, txv_in;

   logic [CHAR_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] tx_data_ff;
   tse_rsp_type       rsp_ff, rsp_in;

   logic              push_req, brk_cand, in_we, in_re, out_we, out_re;
   logic [CHAR_W-1:0] push_char, c;

   assign c = req.data_in[CHAR_W-1:0];

   always_comb begin
      in_wptr_in   = in_wptr_ff;
      in_rptr_in   = in_rptr_ff;
      in_count_in  = in_count_ff;
      out_wptr_in  = out_wptr_ff;
      out_rptr_in  = out_rptr_ff;
      out_space_in = out_space_ff;
      tx_en_in     = tx_en_ff;
      stage_in     = stage_ff;
      lf_pend_in   = lf_pend_ff;
      ovf_in       = ovf_ff;
      brk_in       = brk_ff;
      rdv_in       = rdv_ff;
      wra_in       = wra_ff;
      txv_in       = txv_ff;
      push_req     = 1'b0;
      push_char    = CH_LF;
      brk_cand     = 1'b0;
      in_we        = 1'b0;
      in_re        = 1'b0;
      out_we       = 1'b0;
      out_re       = 1'b0;

      if (cmd.start) begin
         lf_pend_in = 1'b0;
         ovf_in     = 1'b0;
         brk_in     = 1'b0;
         rdv_in     = 1'b0;
         wra_in     = 1'b0;
         txv_in     = 1'b0;
         case (req.op)
            OP_RX: begin
               if (c == CH_ESC) begin
                  if (stage_ff != ESC_STUCK) begin
                     stage_in = stage_ff + 2'd1;
                  end
               end else if (stage_ff == ESC_SEEN && c == CH_LBRACKET) begin
                  stage_in = ESC_CSI;
               end else if (stage_ff == ESC_CSI) begin
                  // cursor up/down store a code now and LF when the result is loaded
                  push_req = 1'b1;
                  stage_in = ESC_IDLE;
                  if (c == CH_A) begin
                     push_char  = CH_VT;
                     lf_pend_in = 1'b1;
                  end else if (c == CH_B) begin
                     push_char  = CH_FF;
                     lf_pend_in = 1'b1;
                  end
               end else if (c == CH_ETX) begin
                  push_req = 1'b1;
                  brk_cand = 1'b1;
               end else begin
                  push_req = 1'b1;
                  if (c == CH_DEL) begin
                     push_char = CH_BS;
                  end else if (c == CH_CR) begin
                     push_char = CH_LF;
                  end else begin
                     push_char = c;
                  end
               end
            end
            OP_READ: begin
               if (in_count_ff != '0) begin
                  in_re       = 1'b1;
                  rdv_in      = 1'b1;
                  in_count_in = in_count_ff - IN_CW'(1);
                  in_rptr_in  = (in_rptr_ff == IN_AW'(IN_DEPTH - 1)) ? '0
                                : in_rptr_ff + IN_AW'(1);
               end
            end
            OP_WRITE: begin
               if (out_space_ff != '0) begin
                  out_we       = 1'b1;
                  wra_in       = 1'b1;
                  tx_en_in     = 1'b1;
                  out_space_in = out_space_ff - OUT_CW'(1);
                  out_wptr_in  = (out_wptr_ff == OUT_AW'(OUT_DEPTH - 1)) ? '0
                                 : out_wptr_ff + OUT_AW'(1);
               end
            end
            OP_TX: begin
               if (out_space_ff >= OUT_CW'(OUT_DEPTH)) begin
                  tx_en_in = 1'b0;
               end else begin
                  out_re       = 1'b1;
                  txv_in       = 1'b1;
                  out_space_in = out_space_ff + OUT_CW'(1);
                  out_rptr_in  = (out_rptr_ff == OUT_AW'(OUT_DEPTH - 1)) ? '0
                                 : out_rptr_ff + OUT_AW'(1);
               end
            end
            default: begin
               tx_en_in = tx_en_ff;
            end
         endcase
      end else if (cmd.finish && lf_pend_ff) begin
         push_req = 1'b1;
      end

      // single push port into the input ring; drop on full
      if (push_req) begin
         if (in_count_ff < IN_CW'(IN_DEPTH)) begin
            in_we       = 1'b1;
            in_count_in = in_count_ff + IN_CW'(1);
            in_wptr_in  = (in_wptr_ff == IN_AW'(IN_DEPTH - 1)) ? '0
                          : in_wptr_ff + IN_AW'(1);
            if (brk_cand) begin
               brk_in = 1'b1;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in.read_char      = rdv_ff ? rd_data_ff : '0;
      rsp_in.read_valid     = rdv_ff;
      rsp_in.write_accepted = wra_ff;
      rsp_in.tx_byte        = txv_ff ? tx_data_ff : '0;
      rsp_in.tx_valid       = txv_ff;
      rsp_in.tx_irq_on      = tx_en_ff;
      rsp_in.break_flag     = brk_in;
      rsp_in.overflow       = ovf_in;
      rsp_in.input_level    = LEVEL_W'(in_count_in);
      rsp_in.output_space   = LEVEL_W'(out_space_ff);
   end

   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_wptr_ff] <= push_char;
      end
      if (in_re) begin
         rd_data_ff <= in_mem[in_rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_wptr_ff] <= req.data_in;
      end
      if (out_re) begin
         tx_data_ff <= out_mem[out_rptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_wptr_ff   <= '0;
         in_rptr_ff   <= '0;
         in_count_ff  <= '0;
         out_wptr_ff  <= '0;
         out_rptr_ff  <= '0;
         out_space_ff <= OUT_CW'(OUT_DEPTH);
         tx_en_ff     <= 1'b0;
         stage_ff     <= ESC_IDLE;
         lf_pend_ff   <= 1'b0;
      end else begin
         in_wptr_ff   <= in_wptr_in;
         in_rptr_ff   <= in_rptr_in;
         in_count_ff  <= in_count_in;
         out_wptr_ff  <= out_wptr_in;
         out_rptr_ff  <= out_rptr_in;
         out_space_ff <= out_space_in;
         tx_en_ff     <= tx_en_in;
         stage_ff     <= stage_in;
         lf_pend_ff   <= lf_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff <= ovf_in;
      brk_ff <= brk_in;
      rdv_ff <= rdv_in;
      wra_ff <= wra_in;
      txv_ff <= txv_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[rtl/tty_serial_ring_buffer_engine.sv]
// Serial TTY ring-buffer engine.
// req channel: one event per transfer, req_payload.op selects a received line
// byte, a software read, a software write or a transmitter-ready event, and
// req_payload.data_in carries the byte for receive and write events.
// rsp channel: exactly one result transfer per event, carrying the popped
// character, write acceptance, the byte for the transmitter, the transmit
// interrupt enable, break and overflow flags and the two ring levels.
// rsp_valid rises when the result register is loaded: the transfer edge
// updates the rings and reads the ring memory, and a later edge in the
// finish state, once the result slot is free, loads the result register.
// An event whose escape sequence stores two characters pushes the line feed
// at that load edge through the single ring write port.
// One event at a time: req_ready is high in the idle state of the
// controller only.
// Reset clears both ring pointers and counts, the escape recognizer and the
// transmit enable; ring contents are not cleared and no clearing pass runs.
// A stalled rsp channel holds the result register; the engine still takes
// the next event, then waits with it until the result register frees up.
`include "tty_serial_ring_buffer_engine_assert.svh"

module tty_serial_ring_buffer_engine
   import tse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tse_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tse_rsp_type rsp_payload
);

   tse_cmd_type cmd;

   // sequence each event: update rings on transfer, then load the result
   tse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // hold both rings, the escape recognizer and the result register
   tse_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .rsp   (rsp_payload)
   );

   // one event in flight: no second transfer right after a transfer
   `TSE_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_valid && req_ready, !req_ready, "engine took two events back to back")
   // a byte still in the output ring keeps the transmit interrupt on
   `TSE_ASSERT_NOW(a_tx_irq_kept, clock, reset,
      rsp_valid && rsp_payload.tx_valid, rsp_payload.tx_irq_on,
      "transmit interrupt off while sending")
   // drop only when the input ring is full
   `TSE_ASSERT_NOW(a_ovf_full, clock, reset,
      rsp_valid && rsp_payload.overflow, rsp_payload.input_level == LEVEL_W'(IN_DEPTH),
      "overflow with room in input ring")
   // read, write and transmit results never mix in one transfer
   `TSE_ASSERT_NOW(a_kinds_apart, clock, reset,
      rsp_valid && rsp_payload.read_valid,
      !rsp_payload.write_accepted && !rsp_payload.tx_valid, "mixed event results")

endmodule

[sim/tty_serial_ring_buffer_engine_test.sv]
module tty_serial_ring_buffer_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tse_pkg::*;

   localparam int CLK_PERIOD       = 20;
   localparam int TIMEOUT_NS       = 5_000_000;
   localparam int MAX_PRINTED      = 40;
   localparam int PHASE_ITEMS      = 100;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 48;
   localparam int DRAIN_LIMIT      = 2000;
   localparam int TAIL_CYCLES      = 10;

   // One line of the directed script: the event, and where the expected
   // result is obvious, that result typed in by hand.
   typedef struct packed {
      tse_op_type        op;
      logic [BYTE_W-1:0] data;
      logic              typed;
      tse_rsp_type       want;
   } script_row_type;

   // Traffic mix of one random phase, in percent; tx-ready takes the rest.
   typedef struct packed {
      int rx_pct;
      int read_pct;
      int write_pct;
      bit idle;
   } mix_type;

   localparam int N_SCRIPT = 24;
   localparam script_row_type SCRIPT [N_SCRIPT] = '{
      // straight out of reset: nothing to read, nothing to send
      '{OP_READ,  8'h00, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 0, 0, 7'd0, 7'd64}},
      '{OP_TX,    8'h00, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 0, 0, 7'd0, 7'd64}},
      // plain byte, DEL as backspace, CR with top bit as LF, Ctrl-C as break
      '{OP_RX,    8'h00, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 0, 0, 7'd1, 7'd64}},
      '{OP_RX,    8'hFF, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 0, 0, 7'd2, 7'd64}},
      '{OP_RX,    8'h8D, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 0, 0, 7'd3, 7'd64}},
      '{OP_RX,    8'h03, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 1, 0, 7'd4, 7'd64}},
      // cursor up: ESC [ A
      '{OP_RX,    8'h1B, 1'b0, '0},
      '{OP_RX,    8'h5B, 1'b0, '0},
      '{OP_RX,    8'h41, 1'b0, '0},
      // cursor down, ESC carrying the top bit
      '{OP_RX,    8'h9B, 1'b0, '0},
      '{OP_RX,    8'h5B, 1'b0, '0},
      '{OP_RX,    8'h42, 1'b0, '0},
      // unknown final byte stores the line feed alone
      '{OP_RX,    8'h1B, 1'b0, '0},
      '{OP_RX,    8'hDB, 1'b0, '0},
      '{OP_RX,    8'h7A, 1'b0, '0},
      // a second ESC also reaches the bracket stage
      '{OP_RX,    8'h1B, 1'b0, '0},
      '{OP_RX,    8'h1B, 1'b0, '0},
      '{OP_RX,    8'h41, 1'b0, '0},
      // ESC then an ordinary byte: byte stored, stage held at one
      '{OP_RX,    8'h1B, 1'b0, '0},
      '{OP_RX,    8'h61, 1'b0, '0},
      // one byte through the output ring, then transmitter ready on empty
      '{OP_WRITE, 8'hFF, 1'b1, '{7'h00, 0, 1, 8'h00, 0, 1, 0, 0, 7'd12, 7'd63}},
      '{OP_READ,  8'h00, 1'b1, '{7'h00, 1, 0, 8'h00, 0, 1, 0, 0, 7'd11, 7'd63}},
      '{OP_TX,    8'h00, 1'b1, '{7'h00, 0, 0, 8'hFF, 1, 1, 0, 0, 7'd11, 7'd64}},
      '{OP_TX,    8'h00, 1'b1, '{7'h00, 0, 0, 8'h00, 0, 0, 0, 0, 7'd11, 7'd64}}
   };

   localparam int N_MIX = 8;
   localparam mix_type MIXES [N_MIX] = '{
      '{30, 30, 20, 1'b1},   // balanced
      '{85,  5,  5, 1'b0},   // flood the input ring
      '{10, 75,  5, 1'b1},   // drain it
      '{ 5,  5, 85, 1'b1},   // flood the output ring
      '{10, 10,  5, 1'b0},   // drain it through the transmitter
      '{70,  5, 20, 1'b1},   // refill input with escape traffic near full
      '{25, 40, 10, 1'b1},   // mostly consume
      '{30, 30, 20, 1'b0}    // recognizer stuck, no idling
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   tse_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   tse_rsp_type rsp_payload;

   // Shared between the sender and the result checker.
   tse_rsp_type pending_rsp_q [$];
   bit          idle_on     = 1'b0;
   int          error_count = 0;
   int          rsp_count   = 0;

   // Shadow copy of the engine: both rings, their levels and the recognizer.
   logic [CHAR_W-1:0] rx_ring [IN_DEPTH];
   logic [IN_AW-1:0]  rx_wr     = '0;
   logic [IN_AW-1:0]  rx_rd     = '0;
   int                rx_level  = 0;
   logic [BYTE_W-1:0] tx_ring [OUT_DEPTH];
   logic [OUT_AW-1:0] tx_wr     = '0;
   logic [OUT_AW-1:0] tx_rd     = '0;
   int                tx_free   = OUT_DEPTH;
   logic              tx_irq    = 1'b0;
   logic [1:0]        esc_state = ESC_IDLE;

   // What the run reached, for the closing summary.
   int op_count [4] = '{0, 0, 0, 0};
   int n_overflow   = 0;
   int n_break      = 0;
   int n_reject     = 0;
   int n_empty_read = 0;
   int n_idle_tx    = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   tty_serial_ring_buffer_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Push one character into the shadow input ring; false when it is full.
   function automatic bit rx_push(input logic [CHAR_W-1:0] ch);
      if (rx_level >= IN_DEPTH) return 1'b0;
      rx_ring[rx_wr] = ch;
      rx_wr = rx_wr + 1'b1;
      rx_level++;
      return 1'b1;
   endfunction

   // Advance the shadow engine by one event and return the result it owes.
   function automatic tse_rsp_type next_tty_response(input tse_req_type ev);
      tse_rsp_type       r;
      logic [CHAR_W-1:0] ch;
      r = '0;
      case (ev.op)
         OP_RX: begin
            ch = ev.data_in[CHAR_W-1:0];
            if (ch == CH_ESC) begin
               // climb one stage per ESC; the top stage is never left
               if (esc_state != ESC_STUCK) esc_state = esc_state + 2'd1;
            end else if (esc_state == ESC_SEEN && ch == CH_LBRACKET) begin
               esc_state = ESC_CSI;
            end else if (esc_state == ESC_CSI) begin
               // cursor keys store their code ahead of the line feed
               if (ch == CH_A) begin
                  if (!rx_push(CH_VT)) r.overflow = 1'b1;
               end else if (ch == CH_B) begin
                  if (!rx_push(CH_FF)) r.overflow = 1'b1;
               end
               if (!rx_push(CH_LF)) r.overflow = 1'b1;
               esc_state = ESC_IDLE;
            end else if (ch == CH_ETX) begin
               if (rx_push(CH_LF)) r.break_flag = 1'b1;
               else r.overflow = 1'b1;
            end else begin
               if (ch == CH_DEL) ch = CH_BS;
               else if (ch == CH_CR) ch = CH_LF;
               if (!rx_push(ch)) r.overflow = 1'b1;
            end
         end
         OP_READ: begin
            if (rx_level > 0) begin
               r.read_char  = rx_ring[rx_rd];
               r.read_valid = 1'b1;
               rx_rd = rx_rd + 1'b1;
               rx_level--;
            end
         end
         OP_WRITE: begin
            if (tx_free > 0) begin
               tx_ring[tx_wr] = ev.data_in;
               tx_wr = tx_wr + 1'b1;
               tx_free--;
               tx_irq = 1'b1;
               r.write_accepted = 1'b1;
            end
         end
         default: begin
            // transmitter ready: an empty ring switches the interrupt off
            if (tx_free >= OUT_DEPTH) begin
               tx_irq = 1'b0;
            end else begin
               r.tx_byte  = tx_ring[tx_rd];
               r.tx_valid = 1'b1;
               tx_rd = tx_rd + 1'b1;
               tx_free++;
            end
         end
      endcase
      r.tx_irq_on    = tx_irq;
      r.input_level  = LEVEL_W'(rx_level);
      r.output_space = LEVEL_W'(tx_free);
      return r;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                rsp_count, name, got, want));
   endtask

   // Compare one result transfer against the oldest pending expectation.
   task automatic check_result(input tse_rsp_type got);
      tse_rsp_type want;
      rsp_count++;
      if (pending_rsp_q.size() == 0) begin
         report_error($sformatf("result %0d arrived with nothing pending", rsp_count));
      end else begin
         want = pending_rsp_q.pop_front();
         check_field("read_char",      got.read_char,      want.read_char);
         check_field("read_valid",     got.read_valid,     want.read_valid);
         check_field("write_accepted", got.write_accepted, want.write_accepted);
         check_field("tx_byte",        got.tx_byte,        want.tx_byte);
         check_field("tx_valid",       got.tx_valid,       want.tx_valid);
         check_field("tx_irq_on",      got.tx_irq_on,      want.tx_irq_on);
         check_field("break_flag",     got.break_flag,     want.break_flag);
         check_field("overflow",       got.overflow,       want.overflow);
         check_field("input_level",    got.input_level,    want.input_level);
         check_field("output_space",   got.output_space,   want.output_space);
      end
   endtask

   // Offer one event and hold it until the transfer; then step the shadow
   // engine and queue the result it owes (or the hand-typed one).
   task automatic send_event(input tse_req_type ev, input bit typed,
                             input tse_rsp_type want);
      tse_rsp_type predicted;
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = next_tty_response(ev);
      pending_rsp_q.push_back(typed ? want : predicted);
      op_count[ev.op]++;
      n_overflow += predicted.overflow;
      n_break    += predicted.break_flag;
      if (ev.op == OP_WRITE && !predicted.write_accepted) n_reject++;
      if (ev.op == OP_READ && !predicted.read_valid) n_empty_read++;
      if (ev.op == OP_TX && !predicted.tx_valid) n_idle_tx++;
   endtask

   // Result side: take transfers, check them, and in idling phases stall
   // the channel in short random bursts, plus one long hold-off that backs
   // the engine up while the sender keeps offering events.
   initial begin : result_sink
      int unsigned stall;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_result(rsp_payload);
         if (!long_hold_done && rsp_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(1, 5);
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin : stimulus
      tse_req_type       ev;
      tse_req_type       batch [$];
      logic [BYTE_W-1:0] burst [$];
      mix_type           mix;
      int                pick;
      int                sent;
      int                wait_cycles;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed script, back to back.
      for (int i = 0; i < N_SCRIPT; i++) begin
         ev.op      = SCRIPT[i].op;
         ev.data_in = SCRIPT[i].data;
         send_event(ev, SCRIPT[i].typed, SCRIPT[i].want);
      end

      for (int p = 0; p < N_MIX; p++) begin
         // Hold the input until every pending result has come back.
         if (pending_rsp_q.size() != 0) begin
            req_valid <= 1'b0;
            while (pending_rsp_q.size() != 0) @(posedge clock);
         end
         mix     = MIXES[p];
         idle_on = mix.idle;

         // Last phase: drive the recognizer into its stuck top stage, with
         // at least one extra ESC to check that it saturates there.
         if (p == N_MIX - 1) begin
            for (int k = 0; k < 4; k++) begin
               ev.op      = OP_RX;
               ev.data_in = {k[0], CH_ESC};
               send_event(ev, 1'b0, '0);
            end
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            batch.delete();
            pick = $urandom_range(0, 99);
            if (pick < mix.rx_pct) begin
               // Mostly well-formed line traffic, some raw noise.
               case ($urandom_range(0, 9))
                  0: burst = '{8'($urandom_range(8'h20, 8'h7E))};
                  1: burst = '{CH_CR};
                  2: burst = '{CH_DEL};
                  3: burst = '{CH_ETX};
                  4: burst = '{CH_ESC, CH_LBRACKET, CH_A};
                  5: burst = '{CH_ESC, CH_LBRACKET, CH_B};
                  6: burst = '{CH_ESC, CH_LBRACKET, 8'($urandom_range(8'h20, 8'h7E))};
                  7: burst = '{CH_ESC, CH_ESC, 8'($urandom_range(8'h40, 8'h43))};
                  8: burst = '{CH_ESC, 8'($urandom_range(8'h20, 8'h5A))};
                  default: burst = '{8'($urandom)};
               endcase
               foreach (burst[i]) begin
                  ev.op      = OP_RX;
                  ev.data_in = {1'($urandom_range(0, 1)), burst[i][CHAR_W-1:0]};
                  batch.push_back(ev);
               end
            end else begin
               ev.data_in = 8'($urandom);
               if (pick < mix.rx_pct + mix.read_pct) ev.op = OP_READ;
               else if (pick < mix.rx_pct + mix.read_pct + mix.write_pct) ev.op = OP_WRITE;
               else ev.op = OP_TX;
               batch.push_back(ev);
            end

            foreach (batch[i]) begin
               if (idle_on && $urandom_range(0, 5) == 0) begin
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 5)) @(posedge clock);
               end
               ev = batch[i];
               // Keep the recognizer out of its stuck stage until the last
               // phase: swap an ESC in the bracket stage for a printable.
               if (ev.op == OP_RX && esc_state == ESC_CSI
                   && ev.data_in[CHAR_W-1:0] == CH_ESC)
                  ev.data_in[CHAR_W-1:0] = 7'($urandom_range(8'h20, 8'h7E));
               send_event(ev, 1'b0, '0);
               sent++;
            end
         end
      end

      // Drop the input and let the last results arrive.
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_rsp_q.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_rsp_q.size()));

      $display("Run: %0d rx bytes, %0d reads, %0d writes, %0d tx-ready; %0d results checked",
               op_count[OP_RX], op_count[OP_READ], op_count[OP_WRITE], op_count[OP_TX],
               rsp_count);
      $display({"Hit: %0d input overflows, %0d breaks, %0d full-ring writes, ",
                "%0d empty reads, %0d empty tx-ready"},
               n_overflow, n_break, n_reject, n_empty_read, n_idle_tx);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[tty_serial_ring_buffer_engine.f]
+incdir+rtl
rtl/tse_pkg.sv
rtl/tse_ctrl.sv
rtl/tse_datapath.sv
rtl/tty_serial_ring_buffer_engine.sv
sim/tty_serial_ring_buffer_engine_test.sv
